// ===== design/tprc_pkg.sv =====
// Shared types and constants of the breathing PWM generator with text commands.
package tprc_pkg;

  localparam int DUTY_W     = 7;
  localparam int PERIOD_W   = 16;
  localparam int PROD_W     = PERIOD_W + DUTY_W;
  localparam int RECIP_W    = 24;
  localparam int RECIP_SHIFT = 30;
  // ceil(2^30 / 100); exact floor division for every product below 2^23.
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  localparam logic [DUTY_W-1:0]   AUTO_TOP     = 7'd99;
  localparam logic [DUTY_W-1:0]   DUTY_MAX     = 7'd127;
  localparam logic [DUTY_W-1:0]   LIMIT_RESET  = 7'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;

  // Only the first nine message bytes are ever examined.
  localparam int STORE_N = 9;

  localparam logic [7:0]  CH_FRAME   = 8'h24;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [63:0] TXT_MANUAL = "$manual$";
  localparam logic [47:0] TXT_AUTO   = "$auto$";
  localparam logic [31:0] TXT_PWM    = "$PWM";

  // Configuration register index (paddr[2]).
  localparam logic REG_PERIOD = 1'b0;

  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_FRAME,
    OP_TEXT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [3:0] digit;
  } cmd_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] compare_value;
    logic [DUTY_W-1:0]   duty;
    logic                manual_mode;
    logic [DUTY_W-1:0]   duty_limit;
    logic                rising;
  } result_t;

endpackage

// ===== design/tprc_fifo.sv =====
// Small register-based FIFO (depth must be a power of two).
module tprc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop) count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== design/tprc_front.sv =====
// Front end: accepts items and classifies them into ticks, frame bytes and text bytes.
module tprc_front
  import tprc_pkg::*;
(
  input  logic      push,
  input  logic      in_cmd,
  input  logic [7:0] in_rx_byte,
  input  logic      q_full,
  output logic      full,
  output logic      q_push,
  output cmd_item_t q_item
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item.ch    = in_rx_byte;
    q_item.digit = '0;
    if (in_cmd) begin
      q_item.op = OP_TICK;
    end else if (in_rx_byte == CH_FRAME) begin
      q_item.op = OP_FRAME;
    end else begin
      q_item.op = OP_TEXT;
    end
    // Any non-digit character counts as zero.
    if (in_rx_byte >= CH_ZERO && in_rx_byte <= CH_NINE) begin
      q_item.digit = in_rx_byte[3:0];
    end
  end

endmodule

// ===== design/tprc_exec.sv =====
// Back end: ramp and command state, then a two-stage compare-count pipeline.
module tprc_exec
  import tprc_pkg::*;
#(
  parameter int MSG_MAX = 35
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [PERIOD_W-1:0] period,
  input  cmd_item_t           q_item,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                res_full,
  output logic                res_push,
  output result_t             res
);

  localparam int CNT_W = $clog2(MSG_MAX + 1);

  // Stage 1: the state itself, holding the result of the last executed item.
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              up_r, up_nxt;
  logic              mode_r, mode_nxt;
  logic [DUTY_W-1:0] limit_r, limit_nxt;
  logic              listen_r, listen_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        store_r [STORE_N];
  logic [7:0]        store_nxt [STORE_N];
  logic [3:0]        dig4_r, dig4_nxt, dig5_r, dig5_nxt;
  logic              s1_valid_r;

  // Stage 2: period * duty. Stage 3: divided by 100.
  logic              s2_valid_r;
  logic [PROD_W-1:0] s2_prod_r;
  result_t           s2_res_r;
  logic              s3_valid_r;
  result_t           s3_res_r;

  logic                      adv;
  logic [DUTY_W-1:0]         top, step;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      listen_now, eq_manual, eq_auto, is_pwm, closing;
  logic [PROD_W+RECIP_W-1:0] scaled;

  assign adv      = !s3_valid_r || !res_full;
  assign q_pop    = adv && !q_empty;
  assign res_push = s3_valid_r;
  assign res      = s3_res_r;
  assign scaled   = s2_prod_r * RECIP_100;

  always_comb begin
    duty_nxt   = duty_r;
    up_nxt     = up_r;
    mode_nxt   = mode_r;
    limit_nxt  = limit_r;
    listen_nxt = listen_r;
    cnt_nxt    = cnt_r;
    store_nxt  = store_r;
    dig4_nxt   = dig4_r;
    dig5_nxt   = dig5_r;
    top        = mode_r ? limit_r : AUTO_TOP;
    step       = duty_r;
    cnt_inc    = cnt_r + CNT_W'(1);
    listen_now = 1'b0;
    eq_manual  = 1'b0;
    eq_auto    = 1'b0;
    is_pwm     = 1'b0;
    closing    = 1'b0;
    if (q_pop) begin
      if (q_item.op == OP_TICK) begin
        if (up_r) begin
          step = (duty_r == DUTY_MAX) ? duty_r : duty_r + DUTY_W'(1);
        end else begin
          step = (duty_r == '0) ? duty_r : duty_r - DUTY_W'(1);
        end
        duty_nxt = step;
        if (step >= top) up_nxt = 1'b0;
        if (step == '0) up_nxt = 1'b1;
      end else begin
        listen_now = listen_r || (q_item.op == OP_FRAME);
        if (listen_now) begin
          for (int k = 0; k < STORE_N; k++) begin
            if (k < MSG_MAX && cnt_r == CNT_W'(k)) store_nxt[k] = q_item.ch;
          end
          if (cnt_r == CNT_W'(4)) dig4_nxt = q_item.digit;
          if (cnt_r == CNT_W'(5)) dig5_nxt = q_item.digit;

          // Text equality also needs the byte after the text to be zero.
          eq_manual = (store_nxt[8] == 8'h00);
          for (int k = 0; k < 8; k++) begin
            if (store_nxt[k] != TXT_MANUAL[8*(7-k) +: 8]) eq_manual = 1'b0;
          end
          eq_auto = (store_nxt[6] == 8'h00);
          for (int k = 0; k < 6; k++) begin
            if (store_nxt[k] != TXT_AUTO[8*(5-k) +: 8]) eq_auto = 1'b0;
          end
          is_pwm = 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (store_nxt[k] != TXT_PWM[8*(3-k) +: 8]) is_pwm = 1'b0;
          end

          if (eq_manual) mode_nxt = 1'b1;
          if (eq_auto) mode_nxt = 1'b0;

          closing = (cnt_inc >= CNT_W'(MSG_MAX)) ||
                    ((q_item.op == OP_FRAME) && (cnt_inc > CNT_W'(1)));
          if (closing) begin
            if (mode_nxt && is_pwm) begin
              limit_nxt = DUTY_W'({dig4_nxt, 3'b000}) + DUTY_W'({dig4_nxt, 1'b0}) +
                          DUTY_W'(dig5_nxt);
            end
            listen_nxt = 1'b0;
            cnt_nxt    = '0;
            for (int k = 0; k < STORE_N; k++) store_nxt[k] = 8'h00;
            dig4_nxt = '0;
            dig5_nxt = '0;
          end else begin
            listen_nxt = 1'b1;
            cnt_nxt    = cnt_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= '0;
      up_r       <= 1'b1;
      mode_r     <= 1'b1;
      limit_r    <= LIMIT_RESET;
      listen_r   <= 1'b0;
      cnt_r      <= '0;
      for (int k = 0; k < STORE_N; k++) store_r[k] <= 8'h00;
      dig4_r     <= '0;
      dig5_r     <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      duty_r   <= duty_nxt;
      up_r     <= up_nxt;
      mode_r   <= mode_nxt;
      limit_r  <= limit_nxt;
      listen_r <= listen_nxt;
      cnt_r    <= cnt_nxt;
      store_r  <= store_nxt;
      dig4_r   <= dig4_nxt;
      dig5_r   <= dig5_nxt;
      if (adv) begin
        s1_valid_r <= q_pop;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r               <= PROD_W'(period) * PROD_W'(duty_r);
      s2_res_r.compare_value  <= '0;
      s2_res_r.duty           <= duty_r;
      s2_res_r.manual_mode    <= mode_r;
      s2_res_r.duty_limit     <= limit_r;
      s2_res_r.rising         <= up_r;
      s3_res_r.compare_value  <= scaled[RECIP_SHIFT +: PERIOD_W];
      s3_res_r.duty           <= s2_res_r.duty;
      s3_res_r.manual_mode    <= s2_res_r.manual_mode;
      s3_res_r.duty_limit     <= s2_res_r.duty_limit;
      s3_res_r.rising         <= s2_res_r.rising;
    end
  end

endmodule

// ===== design/triangle_pwm_ramp_with_text_commands_core.sv =====
// Top level of the breathing PWM generator with a '$'-framed text command receiver.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   input    | push / full        | in_cmd, in_rx_byte
//   result   | pop / empty        | out_compare_value, out_duty, out_manual_mode,
//            |                    | out_duty_limit, out_rising
//   config   | psel/penable/...   | paddr, pwdata, prdata (period at address 0)
//
// The block takes one item per cycle while full is low and returns one item for each.
// A result passes, in order, through the command queue, the state update, the
// period * duty multiplier and the reciprocal multiply that divides by 100, whose
// output is written into the result queue that drives the result ports. It can be
// taken at the next edge.
// Reset is synchronous and active low; it loads period 999, duty 0, a rising ramp,
// manual mode and a limit of 50, and needs no clearing pass.
// A stalled result side fills the result queue and then the command queue; full rises
// only when both are full, and nothing is lost or repeated.
module triangle_pwm_ramp_with_text_commands_core
  import tprc_pkg::*;
#(
  parameter int MSG_MAX = 35
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                push,
  output logic                full,
  input  logic                in_cmd,
  input  logic [7:0]          in_rx_byte,
  // Result channel.
  output logic                empty,
  input  logic                pop,
  output logic [PERIOD_W-1:0] out_compare_value,
  output logic [DUTY_W-1:0]   out_duty,
  output logic                out_manual_mode,
  output logic [DUTY_W-1:0]   out_duty_limit,
  output logic                out_rising,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // The period register scales the duty percent into a timer compare count.
  logic [PERIOD_W-1:0] period_r;
  logic                cfg_wr;

  cmd_item_t q_wr_item, q_rd_item;
  logic      q_push, q_pop, q_full, q_empty;
  result_t   res_wr, res_rd;
  logic      res_push, res_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr && paddr[2] == REG_PERIOD) begin
      period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  // Only one register exists, at every address with paddr[2] low; every other address reads as zero.
  assign prdata = (paddr[2] == REG_PERIOD) ? {{(32-PERIOD_W){1'b0}}, period_r} : '0;

  // The front end classifies each item before it enters the command queue.
  tprc_front u_front (
    .push       (push),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .full       (full),
    .q_push     (q_push),
    .q_item     (q_wr_item)
  );

  // Short queue that lets the front end keep accepting while the back end stalls.
  tprc_fifo #(
    .W     ($bits(cmd_item_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_item),
    .pop     (q_pop),
    .rd_data (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The back end updates the ramp and command state and computes the compare count.
  tprc_exec #(
    .MSG_MAX (MSG_MAX)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .period   (period_r),
    .q_item   (q_rd_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_wr)
  );

  // Result queue; its head is what the result ports show.
  tprc_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .pop     (pop),
    .rd_data (res_rd),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_compare_value = res_rd.compare_value;
  assign out_duty          = res_rd.duty;
  assign out_manual_mode   = res_rd.manual_mode;
  assign out_duty_limit    = res_rd.duty_limit;
  assign out_rising        = res_rd.rising;

endmodule

// ===== design/tprc_checker.sv =====
// Port-level checks of the breathing PWM generator, bound to its top level.
module tprc_checker
  import tprc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input logic [PERIOD_W-1:0] out_compare_value,
  input logic [DUTY_W-1:0]   out_duty,
  input logic [DUTY_W-1:0]   out_duty_limit,
  input logic                out_rising
);

  // A waiting result stays in place until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_compare_value) && $stable(out_duty))
    else $error("waiting result changed before it was taken");

  // The ramp turns at its top, which never exceeds 99.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_duty <= AUTO_TOP)
    else $error("duty above 99");

  // Two decimal digits cannot form a limit above 99.
  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_duty_limit <= AUTO_TOP)
    else $error("duty limit above 99");

  // At zero duty the ramp always rises again.
  a_zero_rises: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_duty == '0 |-> out_rising)
    else $error("ramp falling at zero duty");

endmodule

bind triangle_pwm_ramp_with_text_commands_core tprc_checker u_tprc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .empty             (empty),
  .pop               (pop),
  .out_compare_value (out_compare_value),
  .out_duty          (out_duty),
  .out_duty_limit    (out_duty_limit),
  .out_rising        (out_rising)
);

// ===== sim/triangle_pwm_ramp_with_text_commands_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the breathing PWM generator with '$'-framed text commands.
module triangle_pwm_ramp_with_text_commands_core_tb;
  import tprc_pkg::*;

  // The block's default message length; frames close on their own at this many bytes.
  localparam int FRAME_MAX     = 35;
  localparam int PERCENT       = 100;
  localparam int LONG_GAP      = 16;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_LIMIT   = 50;
  // The period register is register 0, so it sits at byte address 0.
  localparam logic [2:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};

  // Mirrors the ramp and the command receiver, and keeps the results still owed by the block.
  class ramp_scoreboard;
    logic [PERIOD_W-1:0] period;
    logic [DUTY_W-1:0]   duty_pct;
    logic                ramp_up;
    logic                manual;
    logic [DUTY_W-1:0]   top_limit;
    logic                in_frame;
    int                  frame_len;
    logic [7:0]          frame_buf [FRAME_MAX];
    result_t             expected_q [$];
    int                  errors;

    function new();
      period    = PERIOD_RESET;
      duty_pct  = '0;
      ramp_up   = 1'b1;
      manual    = 1'b1;
      top_limit = LIMIT_RESET;
      in_frame  = 1'b0;
      frame_len = 0;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (frame_buf[k]) frame_buf[k] = 8'h00;
    endfunction

    // True when the frame holds exactly the n characters of txt, followed by a zero byte.
    function bit frame_holds(input logic [63:0] txt, input int n);
      for (int k = 0; k < n; k++) begin
        if (frame_buf[k] != txt[8*(n-1-k) +: 8]) return 1'b0;
      end
      if (n < FRAME_MAX && frame_buf[n] != 8'h00) return 1'b0;
      return 1'b1;
    endfunction

    function int digit_value(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      return 0;
    endfunction

    function void ramp_tick();
      logic [DUTY_W-1:0] top;
      top = manual ? top_limit : AUTO_TOP;
      if (ramp_up) begin
        if (duty_pct < DUTY_MAX) duty_pct++;
      end else if (duty_pct > 0) begin
        duty_pct--;
      end
      if (duty_pct >= top) ramp_up = 1'b0;
      if (duty_pct == 0) ramp_up = 1'b1;
    endfunction

    function void take_char(input logic [7:0] c);
      if (c == CH_FRAME) in_frame = 1'b1;
      if (in_frame) begin
        if (frame_len < FRAME_MAX) frame_buf[frame_len] = c;
        if (frame_holds(TXT_MANUAL, 8)) manual = 1'b1;
        if (frame_holds(64'(TXT_AUTO), 6)) manual = 1'b0;
        frame_len++;
      end
      if (frame_len >= FRAME_MAX || (c == CH_FRAME && frame_len > 1 && in_frame)) begin
        if (manual && {frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3]} == TXT_PWM) begin
          top_limit = DUTY_W'(digit_value(frame_buf[4]) * 10 + digit_value(frame_buf[5]));
        end
        in_frame  = 1'b0;
        frame_len = 0;
        clear_frame();
      end
    endfunction

    // Called for every accepted input item.
    function void note_item(input logic is_tick, input logic [7:0] ch);
      result_t r;
      int      cmp;
      if (is_tick) ramp_tick();
      else take_char(ch);
      cmp = (int'(period) * int'(duty_pct)) / PERCENT;
      r.compare_value = cmp[PERIOD_W-1:0];
      r.duty          = duty_pct;
      r.manual_mode   = manual;
      r.duty_limit    = top_limit;
      r.rising        = ramp_up;
      expected_q.push_back(r);
    endfunction

    function void report(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      if (errors <= PRINT_LIMIT) begin
        $display("%0t: %s differs, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    // Called for every accepted result item.
    function void check_result(input result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT) begin
          $display("%0t: result item with none expected, expected nothing, got %p", $time, got);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.compare_value !== want.compare_value)
        report("compare_value", 32'(want.compare_value), 32'(got.compare_value));
      if (got.duty !== want.duty) report("duty", 32'(want.duty), 32'(got.duty));
      if (got.manual_mode !== want.manual_mode)
        report("manual_mode", 32'(want.manual_mode), 32'(got.manual_mode));
      if (got.duty_limit !== want.duty_limit)
        report("duty_limit", 32'(want.duty_limit), 32'(got.duty_limit));
      if (got.rising !== want.rising) report("rising", 32'(want.rising), 32'(got.rising));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                push;
  logic                full;
  logic                in_cmd;
  logic [7:0]          in_rx_byte;
  logic                empty;
  logic                pop;
  logic [PERIOD_W-1:0] out_compare_value;
  logic [DUTY_W-1:0]   out_duty;
  logic                out_manual_mode;
  logic [DUTY_W-1:0]   out_duty_limit;
  logic                out_rising;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  ramp_scoreboard sb;
  int             items_sent;
  logic           sender_idles;

  triangle_pwm_ramp_with_text_commands_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_cmd            (in_cmd),
    .in_rx_byte        (in_rx_byte),
    .empty             (empty),
    .pop               (pop),
    .out_compare_value (out_compare_value),
    .out_duty          (out_duty),
    .out_manual_mode   (out_manual_mode),
    .out_duty_limit    (out_duty_limit),
    .out_rising        (out_rising),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #2 clk = ~clk;

  // Offers one item and returns once the block has taken it. Every forty items the sender
  // picks at random a busy stretch without gaps or a stretch with random gaps. push is
  // only lowered when a gap follows, so back-to-back items keep it high without a glitch.
  task automatic send_item(input logic is_tick, input logic [7:0] ch);
    int gap;
    if (items_sent % 40 == 0) sender_idles = 1'($urandom_range(0, 1));
    gap = sender_idles ? $urandom_range(0, LONG_GAP) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    in_cmd     <= is_tick;
    in_rx_byte <= ch;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(is_tick, ch);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // Mostly a decimal digit, sometimes any byte at all, so that non-digits count as zero.
  function automatic logic [7:0] pick_digit();
    if ($urandom_range(0, 3) != 0) return CH_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom);
  endfunction

  // A write of the period register followed directly by a read-back. The write takes effect
  // at the access edge, which is also where the predictor picks up the new period.
  task automatic write_period(input logic [PERIOD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PERIOD_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.period = value;
    // psel stays high, so this cycle is the setup phase of the read.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(value)) sb.report("prdata", 32'(value), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random traffic until the item count reaches target. Most of it is well-formed commands
  // with random content and runs of ticks long enough to reach the auto-mode top; the rest
  // is frames closed by length, truncated commands and loose bytes.
  task automatic run_random(input int target);
    int         r;
    int         n;
    int         j;
    logic [7:0] b;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 210) : $urandom_range(1, 30);
        repeat (n) send_item(1'b1, 8'($urandom));
      end else if (r < 55) begin
        send_text("$PWM");
        send_item(1'b0, pick_digit());
        send_item(1'b0, pick_digit());
        send_item(1'b0, CH_FRAME);
      end else if (r < 63) begin
        send_text("$manual$");
      end else if (r < 73) begin
        send_text("$auto$");
      end else if (r < 79) begin
        // A frame that never sees a second '$' and closes at the maximum message length. Half of
        // them carry a limit command, which then takes effect at that point in manual mode.
        send_item(1'b0, CH_FRAME);
        n = 0;
        if ($urandom_range(0, 1) != 0) begin
          send_text("PWM");
          n = 3;
        end
        for (j = n; j < FRAME_MAX - 1; j++) begin
          do b = (j < 5) ? pick_digit() : 8'($urandom); while (b == CH_FRAME);
          send_item(1'b0, b);
        end
      end else if (r < 89) begin
        case ($urandom_range(0, 2))
          0:       send_text("$manu");
          1:       send_text("$aut");
          default: send_text("$PW");
        endcase
        send_item(1'b0, 8'($urandom));
        if ($urandom_range(0, 1) != 0) send_item(1'b0, CH_FRAME);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_item(1'b0, ($urandom_range(0, 3) == 0) ? CH_FRAME : 8'($urandom));
        end
      end
    end
  endtask

  // Result side. It too alternates busy and idle stretches, and twice it stops taking
  // results for a long while so that the result queue and then the input side fill up.
  initial begin : result_side
    int   gap;
    int   taken;
    logic rx_idles;
    taken    = 0;
    rx_idles = 1'b1;
    pop     <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 40 == 0) rx_idles = 1'($urandom_range(0, 1));
      if (taken == 400 || taken == 1100) gap = HOLD_CYCLES;
      else gap = rx_idles ? $urandom_range(0, LONG_GAP) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_result('{compare_value: out_compare_value, duty: out_duty,
                        manual_mode: out_manual_mode, duty_limit: out_duty_limit,
                        rising: out_rising});
      taken++;
    end
  end

  initial begin : stimulus
    logic [PERIOD_W-1:0] p;
    sb           = new();
    items_sent   = 0;
    sender_idles = 1'b0;
    rst_n      <= 1'b0;
    push       <= 1'b0;
    in_cmd     <= 1'b0;
    in_rx_byte <= 8'h00;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset period. Ticks carry both extreme byte values,
    // which they must ignore. A limit command with a letter sets the limit to zero, so the
    // rising ramp turns down at the next tick. Bytes outside a frame, the switch to auto
    // mode and an empty frame follow.
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hA5);
    send_text("$PWM0a$");
    send_item(1'b1, 8'h5A);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_text("$auto$");
    send_item(1'b1, 8'h00);
    send_text("$$");
    drain();

    // Random phases, each under its own period: both extremes, zero, the reset value and
    // random values in between.
    for (int k = 0; k < 6; k++) begin
      case (k)
        0:       p = 16'hFFFF;
        1:       p = 16'd1;
        2:       p = 16'd0;
        3:       p = PERIOD_RESET;
        default: p = PERIOD_W'($urandom_range(2, 65534));
      endcase
      write_period(p);
      run_random(23 + (k + 1) * 265);
      drain();
    end

    // Give the block time to show any result that it should not produce.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
